>>> sv/dltq_pkg.sv
// Package for the delta-list timer queue.
// Entry, result and sequencer state types, command and status codes.
// No dependencies.
package dltq_pkg;

    localparam int DELTA_W     = 16;
    localparam int HANDLE_W    = 8;
    localparam int MAX_RESULTS = 16;
    localparam int NPOP_W      = $clog2(MAX_RESULTS + 1);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EXPIRED = 2'd2;

    typedef struct packed {
        logic [DELTA_W-1:0]  delta;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_FOL_WR,
        S_NEW_WR,
        S_RESP,
        S_TICK,
        S_TICK_LAST
    } state_t;

endpackage

>>> sv/dltq_mem.sv
// Entry memory of the timer queue: one write port, one read port,
// read data registered. Uses dltq_pkg.
module dltq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  dltq_pkg::entry_t wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output dltq_pkg::entry_t rdata
);
    import dltq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/dltq_ctrl.sv
// Sequencer of the timer queue: list walk, tail shift, insert, head pop.
// List is a ring in dltq_mem starting at head_reg. Uses dltq_pkg.
module dltq_ctrl #(
    parameter int TIMER_SLOTS = 16,
    parameter int AW          = $clog2(TIMER_SLOTS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_cmd,
    input  logic [dltq_pkg::HANDLE_W-1:0]   in_handle,
    input  logic [dltq_pkg::DELTA_W-1:0]    in_delay,
    input  logic                            out_free,
    output logic                            emit,
    output dltq_pkg::res_t                  res,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output dltq_pkg::entry_t                mem_wdata,
    output logic                            mem_re,
    output logic [AW-1:0]                   mem_raddr,
    input  dltq_pkg::entry_t                mem_rdata
);
    import dltq_pkg::*;

    localparam int LW = AW + 1;
    localparam logic [LW-1:0] SLOTS_L = LW'(TIMER_SLOTS);
    localparam logic [NPOP_W-1:0] MAXR = NPOP_W'(MAX_RESULTS);

    state_t              state_reg, state_next;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [DELTA_W-1:0]  rem_reg, rem_next;
    logic [LW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       j_reg, j_next;
    entry_t              fol_reg, fol_next;
    logic [1:0]          stat_reg, stat_next;
    logic                first_reg, first_next;
    logic                pend_reg, pend_next;
    logic [HANDLE_W-1:0] pend_hnd_reg, pend_hnd_next;
    logic [NPOP_W-1:0]   npop_reg, npop_next;

    logic                zero;
    logic [LW-1:0]       head_inc;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [LW-1:0] l);
        logic [LW-1:0] s;
        s = LW'(h) + l;
        if (s >= SLOTS_L)
        begin
            s = s - SLOTS_L;
        end
        return s[AW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            head_reg  <= '0;
            first_reg <= 1'b0;
            pend_reg  <= 1'b0;
            npop_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            first_reg <= first_next;
            pend_reg  <= pend_next;
            npop_reg  <= npop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hnd_reg      <= hnd_next;
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        fol_reg      <= fol_next;
        stat_reg     <= stat_next;
        pend_hnd_reg <= pend_hnd_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        hnd_next      = hnd_reg;
        rem_next      = rem_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        fol_next      = fol_reg;
        stat_next     = stat_reg;
        first_next    = first_reg;
        pend_next     = pend_reg;
        pend_hnd_next = pend_hnd_reg;
        npop_next     = npop_reg;
        in_ready      = 1'b0;
        emit          = 1'b0;
        res           = '0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        zero          = (mem_rdata.delta == '0) ||
                        (first_reg && (mem_rdata.delta == DELTA_W'(1)));
        head_inc      = LW'(head_reg) + LW'(1);

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    hnd_next = in_handle;
                    if (in_cmd == CMD_ADD)
                    begin
                        rem_next = in_delay;
                        pos_next = '0;
                        if (cnt_reg == SLOTS_L)
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_RESP;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = S_NEW_WR;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = S_WALK;
                        end
                    end
                    else if (cnt_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg;
                        first_next = 1'b1;
                        pend_next  = 1'b0;
                        npop_next  = '0;
                        state_next = S_TICK;
                    end
                end
            end

            S_WALK:
            begin
                if (mem_rdata.delta <= rem_reg)
                begin
                    rem_next = rem_reg - mem_rdata.delta;
                    pos_next = pos_reg + LW'(1);
                    if (pos_reg + LW'(1) == cnt_reg)
                    begin
                        state_next = S_NEW_WR;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(head_reg, pos_reg + LW'(1));
                    end
                end
                else
                begin
                    fol_next.delta  = mem_rdata.delta - rem_reg;
                    fol_next.handle = mem_rdata.handle;
                    if (cnt_reg - LW'(1) > pos_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = phys(head_reg, cnt_reg - LW'(1));
                        j_next     = cnt_reg - LW'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FOL_WR;
                    end
                end
            end

            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, j_reg + LW'(1));
                mem_wdata = mem_rdata;
                if (j_reg - LW'(1) > pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = phys(head_reg, j_reg - LW'(1));
                    j_next    = j_reg - LW'(1);
                end
                else
                begin
                    state_next = S_FOL_WR;
                end
            end

            S_FOL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, pos_reg + LW'(1));
                mem_wdata  = fol_reg;
                state_next = S_NEW_WR;
            end

            S_NEW_WR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = phys(head_reg, pos_reg);
                mem_wdata.delta  = rem_reg;
                mem_wdata.handle = hnd_reg;
                cnt_next         = cnt_reg + LW'(1);
                stat_next        = ST_ADDED;
                state_next       = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res.status = stat_reg;
                    res.handle = hnd_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TICK:
            begin
                if (!pend_reg || out_free)
                begin
                    first_next = 1'b0;
                    if (zero)
                    begin
                        if (pend_reg)
                        begin
                            emit       = 1'b1;
                            res.status = ST_EXPIRED;
                            res.handle = pend_hnd_reg;
                            res.last   = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_hnd_next = mem_rdata.handle;
                        head_next     = (head_inc == SLOTS_L) ? '0 : head_inc[AW-1:0];
                        cnt_next      = cnt_reg - LW'(1);
                        npop_next     = npop_reg + NPOP_W'(1);
                        if ((cnt_reg != LW'(1)) && (npop_reg + NPOP_W'(1) != MAXR))
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = phys(head_reg, LW'(1));
                        end
                        else
                        begin
                            state_next = S_TICK_LAST;
                        end
                    end
                    else if (first_reg)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = head_reg;
                        mem_wdata.delta  = mem_rdata.delta - DELTA_W'(1);
                        mem_wdata.handle = mem_rdata.handle;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        res.status = ST_EXPIRED;
                        res.handle = pend_hnd_reg;
                        res.last   = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end

            S_TICK_LAST:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res.status = ST_EXPIRED;
                    res.handle = pend_hnd_reg;
                    res.last   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOTS_L)
        else $error("entry count above slot count");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result word issued into a busy output register");

    a_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && in_cmd == CMD_ADD && cnt_reg == SLOTS_L)
        |=> (cnt_reg == $past(cnt_reg)) && (head_reg == $past(head_reg)))
        else $error("refused add changed the list");

endmodule

>>> sv/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: sequencer, entry memory and
// output word register. Uses dltq_pkg, dltq_ctrl, dltq_mem.
//
//  channel | dir | tdata              | tuser          | tlast
//  s_*     | in  | handle, delay      | cmd            | -
//  m_*     | out | handle_out         | status         | last
//
// A full queue refuses an add without a walk; else the walk reads one entry a cycle,
// then the tail moves up one entry a cycle through the single write port.
// A tick on a non-empty list pops one expired timer a cycle while the output is free
// (max 16). Reset clears entry count, ring head, state and flags; no memory clearing pass.
// A stalled m_tready holds the sequencer; s_tready is high only between items.
module delta_list_timer_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] handle, [23:8] delay
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] handle_out
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import dltq_pkg::*;

    localparam int AW = $clog2(TIMER_SLOTS);

    logic          emit;
    res_t          res;
    logic          out_free;
    logic          ovalid_reg;
    res_t          ores_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    assign out_free = !ovalid_reg || m_tready;

    dltq_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[0]),
        .in_handle (s_tdata[7:0]),
        .in_delay  (s_tdata[23:8]),
        .out_free  (out_free),
        .emit      (emit),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    dltq_mem #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ores_reg <= res;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ores_reg.handle;
    assign m_tuser  = ores_reg.status;
    assign m_tlast  = ores_reg.last;

endmodule
